// ----- hw/rtl/rws_pkg.sv -----
// Shared types and constants for the roulette wheel selection block.
// No dependencies; every other RTL file imports this package.
package rws_pkg;

   localparam int POP_SIZE    = 32;
   localparam int IDX_W       = $clog2(POP_SIZE);
   localparam int SLOT_W      = 5;
   localparam int FIT_W       = 16;
   localparam int FRAC_W      = 16;
   localparam int TOTAL_W     = FIT_W + IDX_W;
   localparam int PROD_W      = TOTAL_W + FRAC_W;
   localparam int OUT_IDX_W   = 5;
   localparam int OUT_TOTAL_W = 21;
   localparam logic [OUT_TOTAL_W-1:0] TOTAL_MAX = '1;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic KIND_LOAD   = 1'b0;
   localparam logic KIND_SELECT = 1'b1;

   typedef struct packed {
      logic             kind;
      logic [IDX_W-1:0] addr;
      logic [FIT_W-1:0] operand;   // fitness for a load, fraction for a select
   } item_type;

   typedef struct packed {
      logic     push;
      item_type item;
   } push_type;

   typedef struct packed {
      logic     avail;
      item_type item;
   } head_type;

endpackage

// ----- hw/rtl/rws_front.sv -----
// Front end: takes request beats, drops out-of-range loads, packs the operand.
// Depends on rws_pkg.
module rws_front import rws_pkg::*; (
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_kind,
   input  logic [SLOT_W-1:0] req_slot_index,
   input  logic [FIT_W-1:0]  req_fitness_value,
   input  logic [FRAC_W-1:0] req_random_fraction,
   input  logic              queue_full,
   output push_type          push_out
);

   logic in_range;
   logic keep;

   assign in_range  = 32'(req_slot_index) < 32'(POP_SIZE);
   assign keep      = (req_kind == KIND_SELECT) || in_range;
   assign req_ready = !queue_full;

   always_comb begin
      push_out.push         = req_valid && req_ready && keep;
      push_out.item.kind    = req_kind;
      push_out.item.addr    = IDX_W'(req_slot_index);
      push_out.item.operand = (req_kind == KIND_SELECT) ? req_random_fraction
                                                         : req_fitness_value;
   end

endmodule

// ----- hw/rtl/rws_queue.sv -----
// Short item queue between front and back end.
// Depends on rws_pkg.
module rws_queue import rws_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  push_type push_in,
   output logic     full,
   input  logic     pop,
   output head_type head
);

   item_type          slots_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;
   logic              do_pop;

   assign full       = count_ff == (QPTR_W+1)'(QUEUE_DEPTH);
   assign head.avail = count_ff != '0;
   assign head.item  = slots_ff[rd_ptr_ff];
   assign do_pop     = pop && head.avail;

   always_comb begin
      wr_ptr_in = push_in.push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (QPTR_W+1)'(push_in.push) - (QPTR_W+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_in.push) begin
         slots_ff[wr_ptr_ff] <= push_in.item;
      end
   end

endmodule

// ----- hw/rtl/rws_back.sv -----
// Back end: fitness table, running wheel total, threshold multiply and slot walk.
// Depends on rws_pkg.
module rws_back import rws_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  head_type               head_in,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [OUT_IDX_W-1:0]   rsp_chosen_index,
   output logic [OUT_TOTAL_W-1:0] rsp_wheel_total
);

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_LD_RD    = 3'd1;
   localparam logic [2:0] ST_LD_WR    = 3'd2;
   localparam logic [2:0] ST_SEL_MUL  = 3'd3;
   localparam logic [2:0] ST_SEL_WALK = 3'd4;
   localparam logic [2:0] ST_RESP     = 3'd5;

   logic [2:0]             state_ff, state_in;
   logic [IDX_W-1:0]       addr_ff, addr_in;
   logic [FIT_W-1:0]       operand_ff, operand_in;
   logic [TOTAL_W-1:0]     total_ff, total_in;
   logic [TOTAL_W-1:0]     thr_ff, thr_in;
   logic [TOTAL_W-1:0]     run_ff, run_in;
   logic [IDX_W-1:0]       chk_ff, chk_in;
   logic [OUT_IDX_W-1:0]   idx_out_ff, idx_out_in;
   logic [OUT_TOTAL_W-1:0] tot_out_ff, tot_out_in;
   logic [POP_SIZE-1:0]    valid_ff;

   logic [FIT_W-1:0]       fitness_mem [POP_SIZE];
   logic [FIT_W-1:0]       rd_data_ff;
   logic                   rd_valid_ff;
   logic [IDX_W-1:0]       rd_addr;
   logic                   wr_en;
   logic [FIT_W-1:0]       rd_fit;
   logic [PROD_W-1:0]      product;
   logic [TOTAL_W-1:0]     run_sum;
   logic                   hit;

   assign rd_fit  = rd_valid_ff ? rd_data_ff : '0;
   assign product = PROD_W'(total_ff) * PROD_W'(operand_ff);
   assign run_sum = run_ff + TOTAL_W'(rd_fit);
   assign hit     = (run_sum >= thr_ff) || (chk_ff == IDX_W'(POP_SIZE - 1));

   assign pop              = (state_ff == ST_IDLE) && head_in.avail;
   assign rsp_valid        = state_ff == ST_RESP;
   assign rsp_chosen_index = idx_out_ff;
   assign rsp_wheel_total  = tot_out_ff;
   assign wr_en            = state_ff == ST_LD_WR;

   always_comb begin
      case (state_ff)
         ST_LD_RD:    rd_addr = addr_ff;
         ST_SEL_MUL:  rd_addr = '0;
         ST_SEL_WALK: rd_addr = chk_ff + 1'b1;
         default:     rd_addr = addr_ff;
      endcase
   end

   always_comb begin
      state_in   = state_ff;
      addr_in    = addr_ff;
      operand_in = operand_ff;
      total_in   = total_ff;
      thr_in     = thr_ff;
      run_in     = run_ff;
      chk_in     = chk_ff;
      idx_out_in = idx_out_ff;
      tot_out_in = tot_out_ff;
      case (state_ff)
         ST_IDLE: begin
            if (head_in.avail) begin
               addr_in    = head_in.item.addr;
               operand_in = head_in.item.operand;
               state_in   = (head_in.item.kind == KIND_SELECT) ? ST_SEL_MUL : ST_LD_RD;
            end
         end
         ST_LD_RD: begin
            state_in = ST_LD_WR;
         end
         ST_LD_WR: begin
            total_in = total_ff - TOTAL_W'(rd_fit) + TOTAL_W'(operand_ff);
            state_in = ST_IDLE;
         end
         ST_SEL_MUL: begin
            thr_in     = product[PROD_W-1:FRAC_W];
            run_in     = '0;
            chk_in     = '0;
            tot_out_in = (32'(total_ff) > 32'(TOTAL_MAX)) ? TOTAL_MAX
                                                          : OUT_TOTAL_W'(total_ff);
            state_in   = ST_SEL_WALK;
         end
         ST_SEL_WALK: begin
            run_in = run_sum;
            if (hit) begin
               idx_out_in = OUT_IDX_W'(chk_ff);
               state_in   = ST_RESP;
            end else begin
               chk_in = chk_ff + 1'b1;
            end
         end
         ST_RESP: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         total_ff <= '0;
         valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         total_ff <= total_in;
         if (wr_en) begin
            valid_ff[addr_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      addr_ff    <= addr_in;
      operand_ff <= operand_in;
      thr_ff     <= thr_in;
      run_ff     <= run_in;
      chk_ff     <= chk_in;
      idx_out_ff <= idx_out_in;
      tot_out_ff <= tot_out_in;
   end

   // table storage: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         fitness_mem[addr_ff] <= operand_ff;
      end
      rd_data_ff  <= fitness_mem[rd_addr];
      rd_valid_ff <= valid_ff[rd_addr];
   end

endmodule

// ----- hw/rtl/roulette_wheel_selection_top.sv -----
// Roulette wheel selection, top level. Depends on rws_pkg, rws_front, rws_queue, rws_back.
// A load beat holds the back end through its idle, read and write states; a select
//   response follows the multiply state and the walk, which checks one slot a cycle.
// The back end finishes each item, and any stalled response, before it takes the next.
// Reset: synchronous, active high; clears the queue, the wheel total and the per-slot
//   valid bits at once, so every slot reads as zero fitness. No clearing pass.
module roulette_wheel_selection_top import rws_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_kind,
   input  logic [SLOT_W-1:0]      req_slot_index,
   input  logic [FIT_W-1:0]       req_fitness_value,
   input  logic [FRAC_W-1:0]      req_random_fraction,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [OUT_IDX_W-1:0]   rsp_chosen_index,
   output logic [OUT_TOTAL_W-1:0] rsp_wheel_total
);

   // front to queue: classified beats; loads beyond the table are dropped here
   push_type push;
   logic     queue_full;
   // queue to back end: head item and pop
   head_type head;
   logic     pop;

   rws_front u_front (
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_kind            (req_kind),
      .req_slot_index      (req_slot_index),
      .req_fitness_value   (req_fitness_value),
      .req_random_fraction (req_random_fraction),
      .queue_full          (queue_full),
      .push_out            (push)
   );

   // decouples request acceptance from a long select walk or a stalled response
   rws_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push_in (push),
      .full    (queue_full),
      .pop     (pop),
      .head    (head)
   );

   // keeps the wheel total up to date on each load (old value out, new value in),
   // so a select needs only a single walk: multiply for the threshold, then
   // accumulate slot by slot until the running sum reaches it, last slot as fallback
   rws_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_in          (head),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_chosen_index (rsp_chosen_index),
      .rsp_wheel_total  (rsp_wheel_total)
   );

endmodule

// ----- hw/rtl/rws_checker.sv -----
// Port-level checks for the roulette wheel selection top level, bound in below.
// Depends on rws_pkg and roulette_wheel_selection_top.
module rws_checker import rws_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   req_kind,
   input logic [SLOT_W-1:0]      req_slot_index,
   input logic [FIT_W-1:0]       req_fitness_value,
   input logic [FRAC_W-1:0]      req_random_fraction,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [OUT_IDX_W-1:0]   rsp_chosen_index,
   input logic [OUT_TOTAL_W-1:0] rsp_wheel_total
);

   // stalled request beat stays up with its payload
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_kind) &&
         $stable(req_slot_index) && $stable(req_fitness_value) &&
         $stable(req_random_fraction))
      else $error("request beat changed while stalled");

   // stalled response beat stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response beat dropped while stalled");

   // stalled response payload stays put
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_chosen_index) && $stable(rsp_wheel_total))
      else $error("response payload changed while stalled");

   // no response straight out of reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // each select needs a fresh walk: no two response beats back to back
   a_rsp_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |=> !rsp_valid)
      else $error("back-to-back response beats");

endmodule

bind roulette_wheel_selection_top rws_checker u_rws_checker (.*);

// ----- verif/rws_wheel_sb_pkg.sv -----
// Scoreboard for the roulette wheel selection testbench: shadow fitness table,
// selection predictor and the queue of expected picks. Depends on rws_pkg.
package rws_wheel_sb_pkg;
   import rws_pkg::*;

   typedef struct {
      logic [OUT_IDX_W-1:0]   index;
      logic [OUT_TOTAL_W-1:0] total;
   } pick_type;

   class wheel_scoreboard;
      logic [FIT_W-1:0] shadow_fitness [POP_SIZE];
      pick_type         pending_picks [$];
      int               errors;

      function new();
         foreach (shadow_fitness[i]) shadow_fitness[i] = '0;
         pending_picks.delete();
         errors = 0;
      endfunction

      // Spin the wheel: first slot whose running sum reaches total*frac/2^16.
      function pick_type predict_pick(logic [FRAC_W-1:0] frac);
         logic [63:0] sum;
         logic [63:0] thresh;
         logic [63:0] run;
         logic        found;
         pick_type    p;
         sum = '0;
         foreach (shadow_fitness[i]) sum += 64'(shadow_fitness[i]);
         thresh = (sum * 64'(frac)) >> FRAC_W;
         p.index = OUT_IDX_W'(POP_SIZE - 1);
         run = '0;
         found = 1'b0;
         for (int i = 0; i < POP_SIZE; i++) begin
            run += 64'(shadow_fitness[i]);
            if (!found && run >= thresh) begin
               p.index = OUT_IDX_W'(i);
               found = 1'b1;
            end
         end
         p.total = (sum > 64'(TOTAL_MAX)) ? TOTAL_MAX : OUT_TOTAL_W'(sum);
         return p;
      endfunction

      function void note_beat(logic kind, logic [SLOT_W-1:0] slot,
                              logic [FIT_W-1:0] fit, logic [FRAC_W-1:0] frac);
         if (kind == KIND_LOAD) begin
            if (int'(slot) < POP_SIZE) shadow_fitness[slot] = fit;
         end else begin
            pending_picks.push_back(predict_pick(frac));
         end
      endfunction

      function void check_pick(logic [OUT_IDX_W-1:0] index,
                               logic [OUT_TOTAL_W-1:0] total);
         pick_type want;
         if (pending_picks.size() == 0) begin
            $error("unexpected response: chosen_index %0d, wheel_total %0d", index, total);
            errors++;
            return;
         end
         want = pending_picks.pop_front();
         if (index !== want.index) begin
            $error("chosen_index: expected %0d, actual %0d", want.index, index);
            errors++;
         end
         if (total !== want.total) begin
            $error("wheel_total: expected %0d, actual %0d", want.total, total);
            errors++;
         end
      endfunction
   endclass

endpackage

// ----- verif/roulette_wheel_selection_top_tb.sv -----
// Self-checking testbench for roulette_wheel_selection_top.
// Depends on rws_pkg and rws_wheel_sb_pkg; drives random load/select beats.
module roulette_wheel_selection_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rws_pkg::*;
   import rws_wheel_sb_pkg::*;

   localparam int RANDOM_BEATS = 750;
   localparam int DRAIN_CYCLES = 64;   // outlasts a full select walk

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic                   req_kind = KIND_LOAD;
   logic [SLOT_W-1:0]      req_slot_index = '0;
   logic [FIT_W-1:0]       req_fitness_value = '0;
   logic [FRAC_W-1:0]      req_random_fraction = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [OUT_IDX_W-1:0]   rsp_chosen_index;
   logic [OUT_TOTAL_W-1:0] rsp_wheel_total;

   wheel_scoreboard sb = new();

   // burst modes: when set, that side never idles
   bit req_quiet = 1'b0;
   bit rsp_quiet = 1'b0;
   int beats_sent = 0;

   roulette_wheel_selection_top DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_kind            (req_kind),
      .req_slot_index      (req_slot_index),
      .req_fitness_value   (req_fitness_value),
      .req_random_fraction (req_random_fraction),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_chosen_index    (rsp_chosen_index),
      .rsp_wheel_total     (rsp_wheel_total)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Fitness biased towards the corners: zero (a clamped score), full scale, tiny.
   function automatic logic [FIT_W-1:0] pick_fitness();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         2: return FIT_W'($urandom_range(1, 15));
         default: return FIT_W'($urandom);
      endcase
   endfunction

   function automatic logic [FRAC_W-1:0] pick_fraction();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         default: return FRAC_W'($urandom);
      endcase
   endfunction

   // One request beat. Called at a rising edge; returns at the accepting edge with
   // valid still high, so a back-to-back beat never lowers and re-raises it.
   task automatic send_beat(input logic kind, input logic [SLOT_W-1:0] slot,
                            input logic [FIT_W-1:0] fit, input logic [FRAC_W-1:0] frac);
      int gap;
      gap = req_quiet ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_kind            <= kind;
      req_slot_index      <= slot;
      req_fitness_value   <= fit;
      req_random_fraction <= frac;
      // values read here are those the block saw at this edge
      do @(posedge clock); while (!req_ready);
      sb.note_beat(kind, slot, fit, frac);
      beats_sent++;
   endtask

   task automatic select_beat(input logic [FRAC_W-1:0] frac);
      send_beat(KIND_SELECT, SLOT_W'($urandom), FIT_W'($urandom), frac);
   endtask

   task automatic load_beat(input logic [SLOT_W-1:0] slot, input logic [FIT_W-1:0] fit);
      send_beat(KIND_LOAD, slot, fit, FRAC_W'($urandom));
   endtask

   // Response side: random stall per beat, with bursts of no stalling.
   initial begin : rsp_side
      int stall;
      int served;
      served = 0;
      while (reset) @(posedge clock);
      forever begin
         stall = rsp_quiet ? 0 : $urandom_range(0, 18);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         sb.check_pick(rsp_chosen_index, rsp_wheel_total);
         served++;
         if (served % 25 == 0 && $urandom_range(0, 1) == 1) rsp_quiet = ~rsp_quiet;
      end
   end

   initial begin : req_side
      int rand_start;
      int n;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed part ---
      // empty wheel: threshold is zero, slot 0 chosen, total zero
      select_beat('0);
      select_beat('1);
      // a single heavy member at the far end of the table
      load_beat(SLOT_W'(POP_SIZE - 1), '1);
      select_beat('0);               // run of zero already meets zero threshold
      select_beat('1);
      select_beat(16'h8000);
      // light member at slot 0, mid member in the middle
      load_beat('0, 16'd1);
      load_beat(5'd15, 16'h8000);
      select_beat('0);
      select_beat(16'd1);
      select_beat(16'h4000);
      select_beat(16'h7FFF);
      select_beat('1);
      // zero score (software-clamped negative) overwrites the heavy member
      load_beat(SLOT_W'(POP_SIZE - 1), '0);
      select_beat('1);
      select_beat(16'hAAAA);
      // alternating index bits
      load_beat(5'b01010, 16'h5555);
      load_beat(5'b10101, 16'hAAAA);
      select_beat(16'h5555);
      select_beat(16'hAAAA);
      // back to an empty wheel
      load_beat('0, '0);
      load_beat(5'd15, '0);
      load_beat(5'b01010, '0);
      load_beat(5'b10101, '0);
      select_beat(16'hFFFF);

      // --- random part, in phases ---
      rand_start = beats_sent;
      while (beats_sent - rand_start < RANDOM_BEATS) begin
         if ($urandom_range(0, 3) == 0) req_quiet = ~req_quiet;
         case ($urandom_range(0, 9))
            0: begin
               // every slot at full scale: largest wheel total
               for (int s = 0; s < POP_SIZE; s++) load_beat(SLOT_W'(s), '1);
               repeat (4) select_beat(pick_fraction());
            end
            1: begin
               // sparse wheel: wipe, then a few members
               for (int s = 0; s < POP_SIZE; s++) load_beat(SLOT_W'(s), '0);
               n = $urandom_range(1, 3);
               repeat (n) load_beat(SLOT_W'($urandom), pick_fitness());
               repeat (5) select_beat(pick_fraction());
            end
            2: begin
               // noise on the unused fields of both kinds
               repeat (10) send_beat(1'($urandom), SLOT_W'($urandom), FIT_W'($urandom),
                                     FRAC_W'($urandom));
            end
            default: begin
               repeat (20) begin
                  if ($urandom_range(0, 1) == 0) load_beat(SLOT_W'($urandom), pick_fitness());
                  else select_beat(pick_fraction());
               end
            end
         endcase
      end

      req_valid <= 1'b0;
      // wait for every expected pick, then let any stray response show up
      while (sb.pending_picks.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending_picks.size() == 0) begin
         $display("roulette_wheel_selection_top regression: pass");
      end else begin
         $display("roulette_wheel_selection_top regression: fail");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run (~1000 beats).
   initial begin : watchdog
      #4_000_000;
      $display("roulette_wheel_selection_top regression: fail");
      $finish;
   end

endmodule

// ----- roulette_wheel_selection_top.f -----
hw/rtl/rws_pkg.sv
hw/rtl/rws_front.sv
hw/rtl/rws_queue.sv
hw/rtl/rws_back.sv
hw/rtl/roulette_wheel_selection_top.sv
hw/rtl/rws_checker.sv
verif/rws_wheel_sb_pkg.sv
verif/roulette_wheel_selection_top_tb.sv
